// File: sv/bcd_pkg.sv
// Shared codes and control types for the button combo detector.
`default_nettype none

package bcd_pkg;

  // Item kinds carried on the action field
  localparam logic [1:0] ACT_STEP_WRITE = 2'd0;
  localparam logic [1:0] ACT_CMD_WRITE  = 2'd1;
  localparam logic [1:0] ACT_SAMPLE     = 2'd2;

  // Fire behaviors on sequence completion
  localparam logic [1:0] FT_HOLD    = 2'd0;
  localparam logic [1:0] FT_ONCE    = 2'd1;
  localparam logic [1:0] FT_RELEASE = 2'd2;

  // Width of the fire mask result field
  localparam int FIRE_W = 16;

  // Per-command settings handed to the evaluation unit
  typedef struct packed {
    logic       strict;
    logic       waiting;
    logic [1:0] fire_type;
  } cmd_ctl_t;

  // Evaluation outcome flags for one command
  typedef struct packed {
    logic fire;
    logic waiting;
  } eval_res_t;

endpackage

`default_nettype wire

// File: sv/bcd_eval.sv
// Shared match and advance unit: evaluates one command against one sample.
`default_nettype none

module bcd_eval import bcd_pkg::*; #(
  parameter int BW = 32,
  parameter int LW = 3,
  parameter int PW = 2
) (
  input  logic [BW-1:0] sample,
  input  logic [BW-1:0] mask_cur,
  input  logic [BW-1:0] mask_prev,
  input  logic [LW-1:0] length,
  input  logic [PW-1:0] prog,
  input  cmd_ctl_t      ctl,
  output logic [PW-1:0] prog_next,
  output eval_res_t     res
);

  logic          hit_cur;
  logic          hit_prev;
  logic [LW-1:0] prog_inc;
  logic [LW-1:0] len_m1;

  function automatic logic step_match(logic strict, logic [BW-1:0] held,
                                      logic [BW-1:0] m);
    return strict ? (held == m) : ((held & m) == m);
  endfunction

  always_comb begin
    hit_cur     = step_match(ctl.strict, sample, mask_cur);
    hit_prev    = step_match(ctl.strict, sample, mask_prev);
    prog_inc    = LW'(prog) + LW'(1);
    len_m1      = length - LW'(1);
    prog_next   = prog;
    res.fire    = 1'b0;
    res.waiting = ctl.waiting;
    if (length != '0) begin
      if (hit_cur) begin
        if (prog_inc == length) begin
          case (ctl.fire_type)
            FT_HOLD: begin
              res.fire  = 1'b1;
              prog_next = len_m1[PW-1:0];
            end
            FT_ONCE: begin
              res.fire  = 1'b1;
              prog_next = '0;
            end
            FT_RELEASE: begin
              res.fire    = ~ctl.waiting;
              res.waiting = 1'b1;
              prog_next   = len_m1[PW-1:0];
            end
            default: begin
              // unused fire code: complete silently and rearm
              prog_next   = '0;
              res.waiting = 1'b0;
            end
          endcase
        end else begin
          prog_next = prog_inc[PW-1:0];
        end
      end else if (prog != '0 && hit_prev) begin
        res.waiting = 1'b0;
      end else begin
        prog_next   = '0;
        res.waiting = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/button_combo_detector.sv
// Top level of the button combo detector: table storage, command sequencer, result register.
`default_nettype none

// Button combo detector. Each input word is either a table write (a step mask,
// or a command's length, match mode and fire type) or a button sample. A write
// updates the table, clears that command's progress and returns a zero fire
// mask. A sample is checked against every command in turn by a single match
// unit fed from a two-read-port step-mask RAM: one command is issued per cycle
// and evaluated in the next; once the last command is evaluated, the fire mask
// is handed to the output register when that register is free. While an item
// is in progress stall is high; the output register lets a new word be taken
// while the previous fire mask still waits downstream. The step-mask RAM has a
// valid bit per entry, so it reads as zero until written and needs no clearing
// pass after reset. Command slots past the 16 reachable by cmd_index are never
// built.
module button_combo_detector import bcd_pkg::*; #(
  parameter int NUM_COMMANDS = 16,
  parameter int MAX_STEPS    = 4,
  parameter int BUTTON_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [1:0]        action,
  input  logic [3:0]        cmd_index,
  input  logic [1:0]        step_index,
  input  logic [31:0]       button_mask,
  input  logic [2:0]        combo_length,
  input  logic              strict_match,
  input  logic [1:0]        fire_type,
  output logic              fire_valid,
  input  logic              fire_stall,
  output logic [FIRE_W-1:0] fire_mask
);

  // Only slots reachable through the 4-bit index are built
  localparam int NCMD  = (NUM_COMMANDS < 16) ? NUM_COMMANDS : 16;
  localparam int BW    = (BUTTON_BITS < 32) ? BUTTON_BITS : 32;
  localparam int DEPTH = NCMD * MAX_STEPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (NCMD > 1) ? $clog2(NCMD) : 1;
  localparam int LW    = $clog2(MAX_STEPS + 1);
  localparam int PW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     scan_idx;
  logic              issue_done;
  logic              ev_valid;
  logic [CW-1:0]     ev_idx;
  logic [PW-1:0]     ev_p;
  logic [LW-1:0]     ev_len;
  cmd_ctl_t          ev_ctl;
  logic [BW-1:0]     sample_q;
  logic [NCMD-1:0]   acc;
  logic              res_valid;
  logic [FIRE_W-1:0] res_mask;

  // Per-command table and progress
  logic [LW-1:0] len_arr    [NCMD];
  logic          strict_arr [NCMD];
  logic [1:0]    ftype_arr  [NCMD];
  logic [PW-1:0] prog_arr   [NCMD];
  logic          wait_arr   [NCMD];

  // Step-mask RAM
  logic [BW-1:0]    mask_mem [DEPTH];
  logic [DEPTH-1:0] mask_vld;
  logic [BW-1:0]    rd_cur_q;
  logic [BW-1:0]    rd_prev_q;
  logic             vld_cur_q;
  logic             vld_prev_q;

  logic          in_acc;
  logic          wr_cmd_ok;
  logic          wr_step_ok;
  logic          wr_step_en;
  logic          wr_cmd_en;
  logic [CW-1:0] wr_cmd;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] wr_len;
  logic          issuing;
  logic          last_eval;
  logic          post_load;
  logic [LW-1:0] iss_len;
  logic [PW-1:0] iss_p;
  logic [PW-1:0] iss_prev;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] prev_addr;
  logic [BW-1:0] ev_mask_cur;
  logic [BW-1:0] ev_mask_prev;
  logic [PW-1:0] ev_prog_next;
  eval_res_t     ev_res;

  assign stall      = (state != ST_IDLE);
  assign in_acc     = valid & ~stall;
  assign fire_valid = res_valid;
  assign fire_mask  = res_mask;

  // Write decode: drop writes aimed past the built table
  always_comb begin
    wr_cmd_ok  = int'(cmd_index) < NCMD;
    wr_step_ok = int'(step_index) < MAX_STEPS;
    wr_cmd     = CW'(cmd_index);
    wr_addr    = AW'(int'(wr_cmd) * MAX_STEPS + int'(step_index));
    wr_len     = (int'(combo_length) > MAX_STEPS) ? LW'(MAX_STEPS) : LW'(combo_length);
    wr_step_en = in_acc && action == ACT_STEP_WRITE && wr_cmd_ok && wr_step_ok;
    wr_cmd_en  = in_acc && action == ACT_CMD_WRITE && wr_cmd_ok;
  end

  // Issue side: pick current and previous step of the command being issued
  always_comb begin
    issuing  = (state == ST_SCAN) && !issue_done;
    iss_len  = len_arr[scan_idx];
    iss_p    = (LW'(prog_arr[scan_idx]) >= iss_len) ? '0 : prog_arr[scan_idx];
    iss_prev = (iss_p == '0) ? '0 : iss_p - PW'(1);
    cur_addr  = AW'(int'(scan_idx) * MAX_STEPS + int'(iss_p));
    prev_addr = AW'(int'(scan_idx) * MAX_STEPS + int'(iss_prev));
    last_eval = ev_valid && ev_idx == CW'(NCMD - 1);
    post_load = (state == ST_POST) && (!res_valid || !fire_stall);
  end

  // Never-written entries read as zero
  assign ev_mask_cur  = vld_cur_q ? rd_cur_q : '0;
  assign ev_mask_prev = vld_prev_q ? rd_prev_q : '0;

  always_ff @(posedge clk) begin
    if (wr_step_en) begin
      mask_mem[wr_addr] <= button_mask[BW-1:0];
    end
    rd_cur_q  <= mask_mem[cur_addr];
    rd_prev_q <= mask_mem[prev_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_vld   <= '0;
      vld_cur_q  <= 1'b0;
      vld_prev_q <= 1'b0;
    end else begin
      if (wr_step_en) begin
        mask_vld[wr_addr] <= 1'b1;
      end
      vld_cur_q  <= mask_vld[cur_addr];
      vld_prev_q <= mask_vld[prev_addr];
    end
  end

  // Shared evaluation unit, one command per cycle
  bcd_eval #(
    .BW(BW),
    .LW(LW),
    .PW(PW)
  ) u_eval (
    .sample    (sample_q),
    .mask_cur  (ev_mask_cur),
    .mask_prev (ev_mask_prev),
    .length    (ev_len),
    .prog      (ev_p),
    .ctl       (ev_ctl),
    .prog_next (ev_prog_next),
    .res       (ev_res)
  );

  // Command table and progress
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCMD; i++) begin
        len_arr[i]    <= '0;
        strict_arr[i] <= 1'b0;
        ftype_arr[i]  <= FT_HOLD;
        prog_arr[i]   <= '0;
        wait_arr[i]   <= 1'b0;
      end
    end else begin
      if (wr_cmd_en) begin
        len_arr[wr_cmd]    <= wr_len;
        strict_arr[wr_cmd] <= strict_match;
        ftype_arr[wr_cmd]  <= fire_type;
      end
      if (wr_cmd_en || wr_step_en) begin
        prog_arr[wr_cmd] <= '0;
        wait_arr[wr_cmd] <= 1'b0;
      end
      // disabled commands keep their state untouched
      if (ev_valid && ev_len != '0) begin
        prog_arr[ev_idx] <= ev_prog_next;
        wait_arr[ev_idx] <= ev_res.waiting;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      issue_done <= 1'b0;
      ev_valid   <= 1'b0;
    end else begin
      ev_valid <= issuing;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (action == ACT_SAMPLE) begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              issue_done <= 1'b0;
            end else begin
              state <= ST_POST;
            end
          end
        end
        ST_SCAN: begin
          if (!issue_done) begin
            if (scan_idx == CW'(NCMD - 1)) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + CW'(1);
            end
          end
          if (last_eval) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (post_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Issue-to-evaluate payload and fire accumulation
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_q <= button_mask[BW-1:0];
      acc      <= '0;
    end
    if (issuing) begin
      ev_idx         <= scan_idx;
      ev_p           <= iss_p;
      ev_len         <= iss_len;
      ev_ctl.strict    <= strict_arr[scan_idx];
      ev_ctl.waiting   <= wait_arr[scan_idx];
      ev_ctl.fire_type <= ftype_arr[scan_idx];
    end
    if (ev_valid) begin
      acc[ev_idx] <= ev_res.fire;
    end
    if (post_load) begin
      res_mask <= FIRE_W'(acc);
    end
  end

  // Output register: load wins over drain
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (post_load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !fire_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/bcd_checker.sv
// Port-level checker for the button combo detector, with its bind.
`default_nettype none

module bcd_checker import bcd_pkg::*; #(
  parameter int NUM_COMMANDS = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              stall,
  input logic              fire_valid,
  input logic              fire_stall,
  input logic [FIRE_W-1:0] fire_mask
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend;

  assign in_acc  = valid & ~stall;
  assign out_acc = fire_valid & ~fire_stall;

  // Words taken but whose fire mask is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> stall)
    else $error("block took a word and did not go busy");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    fire_valid |-> pend != 2'd0)
    else $error("result shown with no word outstanding");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    fire_valid && fire_stall |=> fire_valid && $stable(fire_mask))
    else $error("stalled result changed");

  a_fire_in_range: assert property (@(posedge clk) disable iff (rst)
    fire_valid |-> (64'(fire_mask) >> NUM_COMMANDS) == 64'd0)
    else $error("fire bit set for a command that does not exist");

endmodule

bind button_combo_detector bcd_checker #(
  .NUM_COMMANDS(NUM_COMMANDS)
) u_bcd_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (valid),
  .stall      (stall),
  .fire_valid (fire_valid),
  .fire_stall (fire_stall),
  .fire_mask  (fire_mask)
);

`default_nettype wire
